// ===== src/kte_pkg.sv =====
// Shared types and constants for the keypad threshold entry and alarm block.
// No dependencies; imported by every module of the block.
package kte_pkg;

  // key codes (ASCII)
  localparam logic [7:0] KEY_STAR = 8'h2A;
  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_NONE = 8'h45;
  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_NINE = 8'h39;

  // entry modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_HIGH = 2'd1;
  localparam logic [1:0] MODE_LOW  = 2'd2;

  // alarm codes
  localparam logic [1:0] ALARM_NORMAL = 2'd0;
  localparam logic [1:0] ALARM_LOW    = 2'd1;
  localparam logic [1:0] ALARM_HIGH   = 2'd2;

  // request kinds
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // largest value an entry can hold
  localparam logic [9:0] VALUE_MAX = 10'd999;

  typedef struct packed {
    logic              req_type;
    logic [11:0]       key_matrix;
    logic signed [15:0] temperature;
  } in_item_t;

  typedef struct packed {
    logic       key_valid;
    logic [7:0] key_code;
    logic       log_request;
    logic [1:0] mode_now;
    logic [3:0] digits_typed;
    logic [9:0] high_threshold;
    logic [9:0] low_threshold;
    logic [1:0] alarm;
  } out_item_t;

  // key release handed from the debouncer to the entry logic
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
  } key_evt_t;

  // entry and alarm state after the current transaction
  typedef struct packed {
    logic       log_request;
    logic [1:0] mode;
    logic [3:0] count;
    logic [9:0] high_limit;
    logic [9:0] low_limit;
    logic [1:0] alarm;
  } entry_stat_t;

  // keypad layout: rows 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
  function automatic logic [7:0] key_ascii(input logic [1:0] row, input logic [1:0] col);
    logic [7:0] code;
    code = KEY_NONE;
    unique case (row)
      2'd0: code = (col == 2'd0) ? 8'h31 : (col == 2'd1) ? 8'h32 : 8'h33;
      2'd1: code = (col == 2'd0) ? 8'h34 : (col == 2'd1) ? 8'h35 : 8'h36;
      2'd2: code = (col == 2'd0) ? 8'h37 : (col == 2'd1) ? 8'h38 : 8'h39;
      2'd3: code = (col == 2'd0) ? KEY_STAR : (col == 2'd1) ? KEY_ZERO : KEY_HASH;
      default: code = KEY_NONE;
    endcase
    return code;
  endfunction

endpackage

// ===== src/kte_debounce.sv =====
// Keypad press debouncer and key scanner; reports a key on its release.
// Depends on kte_pkg.
module kte_debounce import kte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic [11:0] key_matrix,
  output key_evt_t    evt
);

  typedef enum logic [1:0] {
    PH_PRESS   = 2'd0,
    PH_PRESS2  = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] held_key, held_key_next;
  logic [2:0] col_hit;
  logic [3:0] row_hit;
  logic [7:0] scan_code;
  logic       pressed;

  // column and row activity
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_hit[c] = key_matrix[c] | key_matrix[c+3] | key_matrix[c+6] | key_matrix[c+9];
    end
    for (int r = 0; r < 4; r++) begin
      row_hit[r] = |key_matrix[r*3 +: 3];
    end
  end

  // lowest active column, then first active row
  always_comb begin
    logic [1:0] col;
    col = 2'd0;
    scan_code = KEY_NONE;
    priority if (col_hit[0]) col = 2'd0;
    else if (col_hit[1]) col = 2'd1;
    else col = 2'd2;
    if (col_hit != 3'b000) begin
      priority if (row_hit[0]) scan_code = key_ascii(2'd0, col);
      else if (row_hit[1]) scan_code = key_ascii(2'd1, col);
      else if (row_hit[2]) scan_code = key_ascii(2'd2, col);
      else scan_code = key_ascii(2'd3, col);
    end
  end

  assign pressed = (key_matrix != 12'd0);

  // debounce sequence
  always_comb begin
    phase_next    = phase;
    held_key_next = held_key;
    evt.valid     = 1'b0;
    evt.code      = 8'd0;
    if (tick) begin
      unique case (phase)
        PH_PRESS: begin
          if (pressed && held_key == 8'd0) phase_next = PH_PRESS2;
        end
        PH_PRESS2: begin
          if (pressed) begin
            held_key_next = scan_code;
            phase_next    = PH_RELEASE;
          end else begin
            phase_next = PH_PRESS;
          end
        end
        PH_RELEASE: begin
          if (!pressed) begin
            phase_next    = PH_PRESS;
            evt.valid     = 1'b1;
            evt.code      = held_key;
            held_key_next = 8'd0;
          end
        end
        default: phase_next = PH_PRESS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_PRESS;
      held_key <= 8'd0;
    end else begin
      phase    <= phase_next;
      held_key <= held_key_next;
    end
  end

endmodule

// ===== src/kte_entry.sv =====
// Limit entry sequencer and temperature alarm compare.
// Depends on kte_pkg; takes key releases from kte_debounce.
module kte_entry import kte_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample,
  input  logic signed [15:0] temperature,
  input  key_evt_t           evt,
  output entry_stat_t        stat_next
);

  localparam logic [3:0] MaxCount = 4'(MAX_DIGITS);

  logic [1:0]  mode;
  logic [3:0]  count;
  logic [9:0]  value, value_next;
  logic [9:0]  high_limit, low_limit;
  logic [1:0]  alarm;
  logic        in_entry;
  logic        is_digit;
  logic [13:0] acc;
  logic signed [18:0] temp_ext, hi_ext, lo_ext;

  assign in_entry = (mode == MODE_HIGH) || (mode == MODE_LOW);
  assign is_digit = (evt.code >= KEY_ZERO) && (evt.code <= KEY_NINE);
  assign acc      = 14'(value) * 14'd10 + 14'(evt.code - KEY_ZERO);

  // Q8.8 sample against whole-degree limits
  assign temp_ext = 19'(temperature);
  assign hi_ext   = signed'({1'b0, high_limit, 8'd0});
  assign lo_ext   = signed'({1'b0, low_limit, 8'd0});

  // key handling and alarm update
  always_comb begin
    stat_next.log_request = 1'b0;
    stat_next.mode        = mode;
    stat_next.count       = count;
    stat_next.high_limit  = high_limit;
    stat_next.low_limit   = low_limit;
    stat_next.alarm       = alarm;
    value_next            = value;
    if (evt.valid) begin
      priority if (evt.code == KEY_STAR) begin
        stat_next.log_request = 1'b1;
        stat_next.mode        = MODE_IDLE;
        stat_next.count       = 4'd0;
        value_next            = 10'd0;
      end else if (evt.code == KEY_HASH) begin
        stat_next.count = 4'd0;
        value_next      = 10'd0;
        priority if (mode == MODE_HIGH) begin
          stat_next.high_limit = value;
          stat_next.mode       = MODE_LOW;
        end else if (mode == MODE_LOW) begin
          stat_next.low_limit = value;
          stat_next.mode      = MODE_IDLE;
        end else begin
          stat_next.mode = MODE_HIGH;
        end
      end else if (in_entry && is_digit && count < MaxCount) begin
        value_next      = (acc > 14'(VALUE_MAX)) ? VALUE_MAX : acc[9:0];
        stat_next.count = count + 4'd1;
      end else begin
        // any other key leaves the entry as it is
        value_next = value;
      end
    end
    if (sample && !in_entry) begin
      priority if (temp_ext >= hi_ext) stat_next.alarm = ALARM_HIGH;
      else if (temp_ext <= lo_ext) stat_next.alarm = ALARM_LOW;
      else stat_next.alarm = ALARM_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      count      <= 4'd0;
      value      <= 10'd0;
      high_limit <= 10'd0;
      low_limit  <= 10'd0;
      alarm      <= ALARM_NORMAL;
    end else begin
      mode       <= stat_next.mode;
      count      <= stat_next.count;
      value      <= value_next;
      high_limit <= stat_next.high_limit;
      low_limit  <= stat_next.low_limit;
      alarm      <= stat_next.alarm;
    end
  end

endmodule

// ===== src/keypad_threshold_entry_alarm_top.sv =====
// Keypad threshold entry with temperature alarm, top level.
// All work is one pass of logic; the result is in the output register the next cycle.
// Throughput: one transaction per cycle unless out_stall holds a full output register.
// A transaction is taken whenever the output register is empty or being emptied.
// Reset (synchronous, rst high) clears the output valid, the debouncer and all limits.
// Depends on kte_pkg, kte_debounce and kte_entry.
module keypad_threshold_entry_alarm_top import kte_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        accept;
  key_evt_t    evt;
  entry_stat_t stat_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  kte_debounce u_debounce (
    .clk        (clk),
    .rst        (rst),
    .tick       (accept && in_data.req_type == REQ_TICK),
    .key_matrix (in_data.key_matrix),
    .evt        (evt)
  );

  kte_entry #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_entry (
    .clk         (clk),
    .rst         (rst),
    .sample      (accept && in_data.req_type == REQ_SAMPLE),
    .temperature (in_data.temperature),
    .evt         (evt),
    .stat_next   (stat_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.key_valid      <= evt.valid;
      out_data.key_code       <= evt.code;
      out_data.log_request    <= stat_next.log_request;
      out_data.mode_now       <= stat_next.mode;
      out_data.digits_typed   <= stat_next.count;
      out_data.high_threshold <= stat_next.high_limit;
      out_data.low_threshold  <= stat_next.low_limit;
      out_data.alarm          <= stat_next.alarm;
    end
  end

endmodule
